// ===== hw/rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// shared constants and codes for the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int MAX_POP        = 32;
    localparam int TIME_W         = 32;
    localparam int PERIOD_W       = 31;
    localparam int HANDLE_W       = 5;
    localparam int POP_CNT_W      = 6;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_DEL   = 3'd1;
    localparam logic [2:0] OP_RUN   = 3'd2;
    localparam logic [2:0] OP_SETI  = 3'd3;
    localparam logic [2:0] OP_REARM = 3'd4;
    localparam logic [2:0] OP_NEXT  = 3'd5;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_STATE = 2'd2;

    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_QUEUED  = 2'd1;
    localparam logic [1:0] SLOT_EXPIRED = 2'd2;

endpackage

// ===== hw/rtl/stq_alu.sv =====
// ----------------------------------------------------------------------------
// stq_alu
// shared 32-bit add/subtract unit with wrapping later-than flag
// ----------------------------------------------------------------------------
module stq_alu (
    input  logic [stq_pkg::TIME_W-1:0] i_a,
    input  logic [stq_pkg::TIME_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [stq_pkg::TIME_W-1:0] o_sum,
    output logic                       o_later
);

    logic [stq_pkg::TIME_W-1:0] b_op;

    assign b_op    = i_sub ? ~i_b : i_b;
    assign o_sum   = i_a + b_op + stq_pkg::TIME_W'(i_sub);
    assign o_later = i_sub && (o_sum != '0) && !o_sum[stq_pkg::TIME_W-1];

endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// slot table of wrapping ms timers kept in a queue sorted by due time
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | opcode, timer_handle, delay_ms,
//         |           |                    | now_ms, again
// output  | out       | o_valid / i_stall  | result_handle, expired_valid,
//         |           |                    | next_in_ms, status, last_result
//
// one transaction at a time; a sequencer walks the order, due and period
// memories through one shared adder, one read port per memory; a sorted
// insert scans (order read, due read, compare), then shifts (read, write);
// delete scans (read, compare), and it and each pop close the gap (read, write
// per moved entry); add scans slots one per cycle; reset is synchronous and
// needs no clearing pass; a stalled result holds its state until taken
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [4:0]  i_timer_handle,
    input  logic [30:0] i_delay_ms,
    input  logic [31:0] i_now_ms,
    input  logic        i_again,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_result_handle,
    output logic        o_expired_valid,
    output logic [31:0] o_next_in_ms,
    output logic [1:0]  o_status,
    output logic        o_last_result
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IW = SW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_FREE_SCAN, S_ENQ_RDO, S_ENQ_RDD, S_ENQ_CMP,
        S_SHIFT_RD, S_SHIFT_WR, S_DEL_RD, S_DEL_CMP, S_REM_RD, S_REM_WR,
        S_RUN_CHK, S_RUN_RDD, S_RUN_CMP, S_RUN_POP, S_REARM_RD, S_REARM_ADD,
        S_NEXT_RDD, S_NEXT_SUB, S_RESP
    } t_state;

    t_state r_state;

    logic [2:0]  r_op;
    logic [4:0]  r_h;
    logic [30:0] r_dly;
    logic [31:0] r_now;
    logic        r_again;
    logic [IW-1:0] r_len, r_idx, r_pos;
    logic [SW-1:0] r_slot, r_pend;
    logic          r_have_pend;
    logic [stq_pkg::POP_CNT_W-1:0] r_cnt;
    logic [31:0]   r_due;
    logic [1:0]    r_st [NUM_TIMERS];

    logic [4:0]  r_o_handle;
    logic        r_o_ev, r_o_valid, r_o_last;
    logic [31:0] r_o_nx;
    logic [1:0]  r_o_status;

    logic [SW-1:0] m_order [NUM_TIMERS];
    logic [31:0]   m_due   [NUM_TIMERS];
    logic [30:0]   m_per   [NUM_TIMERS];
    logic [SW-1:0] r_ord_q;
    logic [31:0]   r_due_q;
    logic [30:0]   r_per_q;

    logic [SW-1:0] ord_ra, ord_wa, ord_wd, due_ra, due_wa, per_wa, hslot;
    logic          ord_we, due_we, per_we;
    logic [31:0]   due_wd;
    logic [30:0]   per_wd;
    logic [31:0]   alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_later, hok, scan_free;

    assign hslot     = SW'(r_h);
    assign hok       = int'(r_h) < NUM_TIMERS;
    assign scan_free = r_st[r_idx[SW-1:0]] == stq_pkg::SLOT_FREE;

    stq_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_later (alu_later)
    );

    always_comb begin
        alu_a   = r_due_q;
        alu_b   = r_now;
        alu_sub = 1'b1;
        unique case (r_state)
            S_FREE_SCAN: begin
                alu_a   = r_now;
                alu_b   = {1'b0, r_dly};
                alu_sub = 1'b0;
            end
            S_REARM_ADD: begin
                alu_b   = {1'b0, r_per_q};
                alu_sub = 1'b0;
            end
            S_ENQ_CMP: alu_b = r_due;
            default: ;
        endcase
    end

    always_comb begin
        ord_ra = '0;
        ord_we = 1'b0;
        ord_wa = r_idx[SW-1:0];
        ord_wd = r_ord_q;
        due_ra = r_ord_q;
        due_we = 1'b0;
        due_wa = hslot;
        due_wd = alu_sum;
        per_we = 1'b0;
        per_wa = hslot;
        per_wd = r_dly;
        unique case (r_state)
            S_ENQ_RDO: ord_ra = r_idx[SW-1:0];
            S_DEL_RD:  ord_ra = r_idx[SW-1:0];
            S_REM_RD:  ord_ra = SW'(r_idx + IW'(1));
            S_SHIFT_RD: begin
                ord_ra = SW'(r_idx - IW'(1));
                if (r_idx == r_pos) begin
                    ord_we = 1'b1;
                    ord_wa = r_pos[SW-1:0];
                    ord_wd = r_slot;
                end
            end
            S_SHIFT_WR, S_REM_WR: ord_we = 1'b1;
            S_REARM_RD: due_ra = hslot;
            S_FREE_SCAN: begin
                if (scan_free) begin
                    due_we = 1'b1;
                    due_wa = r_idx[SW-1:0];
                    per_we = 1'b1;
                    per_wa = r_idx[SW-1:0];
                end
            end
            S_REARM_ADD: due_we = 1'b1;
            S_DISPATCH: begin
                if (r_op == stq_pkg::OP_SETI && hok &&
                    r_st[hslot] != stq_pkg::SLOT_FREE) begin
                    per_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            m_order[ord_wa] <= ord_wd;
        end
        if (due_we) begin
            m_due[due_wa] <= due_wd;
        end
        if (per_we) begin
            m_per[per_wa] <= per_wd;
        end
        r_ord_q <= m_order[ord_ra];
        r_due_q <= m_due[due_ra];
        r_per_q <= m_per[hslot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_o_valid   <= 1'b0;
            r_have_pend <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_st[k] <= stq_pkg::SLOT_FREE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op       <= i_opcode;
                        r_h        <= i_timer_handle;
                        r_dly      <= i_delay_ms;
                        r_now      <= i_now_ms;
                        r_again    <= i_again;
                        r_o_handle <= '0;
                        r_o_ev     <= 1'b0;
                        r_o_nx     <= '0;
                        r_o_status <= stq_pkg::STS_OK;
                        r_o_last   <= 1'b1;
                        r_idx      <= '0;
                        r_cnt      <= '0;
                        r_have_pend <= 1'b0;
                        r_state    <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_state <= S_RESP;
                    case (r_op)
                        stq_pkg::OP_ADD: r_state <= S_FREE_SCAN;
                        stq_pkg::OP_DEL: begin
                            if (!hok || r_st[hslot] != stq_pkg::SLOT_QUEUED) begin
                                r_o_status <= stq_pkg::STS_STATE;
                            end else begin
                                r_state <= S_DEL_RD;
                            end
                        end
                        stq_pkg::OP_RUN: r_state <= S_RUN_CHK;
                        stq_pkg::OP_SETI: begin
                            if (!hok || r_st[hslot] == stq_pkg::SLOT_FREE) begin
                                r_o_status <= stq_pkg::STS_STATE;
                            end
                        end
                        stq_pkg::OP_REARM: begin
                            if (!hok || r_st[hslot] != stq_pkg::SLOT_EXPIRED) begin
                                r_o_status <= stq_pkg::STS_STATE;
                            end else if (r_again) begin
                                r_state <= S_REARM_RD;
                            end else begin
                                r_st[hslot] <= stq_pkg::SLOT_FREE;
                            end
                        end
                        stq_pkg::OP_NEXT: begin
                            if (r_len != '0) begin
                                r_state <= S_NEXT_RDD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_FREE_SCAN: begin
                    if (scan_free) begin
                        r_slot  <= r_idx[SW-1:0];
                        r_due   <= alu_sum;
                        r_idx   <= '0;
                        r_state <= S_ENQ_RDO;
                    end else if (r_idx == IW'(NUM_TIMERS - 1)) begin
                        r_o_status <= stq_pkg::STS_FULL;
                        r_state    <= S_RESP;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_ENQ_RDO: begin
                    if (r_idx == r_len) begin
                        r_pos   <= r_idx;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_state <= S_ENQ_RDD;
                    end
                end
                S_ENQ_RDD: r_state <= S_ENQ_CMP;
                S_ENQ_CMP: begin
                    if (alu_later) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_len;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_ENQ_RDO;
                    end
                end
                S_SHIFT_RD: begin
                    if (r_idx == r_pos) begin
                        r_len        <= r_len + IW'(1);
                        r_st[r_slot] <= stq_pkg::SLOT_QUEUED;
                        if (r_op == stq_pkg::OP_ADD) begin
                            r_o_handle <= 5'(r_slot);
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= r_idx - IW'(1);
                    r_state <= S_SHIFT_RD;
                end
                S_DEL_RD: begin
                    if (r_idx == r_len) begin
                        r_st[hslot] <= stq_pkg::SLOT_FREE;
                        r_state     <= S_RESP;
                    end else begin
                        r_state <= S_DEL_CMP;
                    end
                end
                S_DEL_CMP: begin
                    if (r_ord_q == hslot) begin
                        r_state <= S_REM_RD;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_DEL_RD;
                    end
                end
                S_REM_RD: begin
                    if (r_idx + IW'(1) >= r_len) begin
                        r_len <= r_len - IW'(1);
                        if (r_op == stq_pkg::OP_DEL) begin
                            r_st[hslot] <= stq_pkg::SLOT_FREE;
                            r_state     <= S_RESP;
                        end else begin
                            r_state <= S_RUN_CHK;
                        end
                    end else begin
                        r_state <= S_REM_WR;
                    end
                end
                S_REM_WR: begin
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_REM_RD;
                end
                S_RUN_CHK: begin
                    if (r_cnt == stq_pkg::POP_CNT_W'(stq_pkg::MAX_POP) || r_len == '0) begin
                        if (r_have_pend) begin
                            r_o_handle <= 5'(r_pend);
                            r_o_ev     <= 1'b1;
                            r_o_last   <= 1'b1;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_RUN_RDD;
                    end
                end
                S_RUN_RDD: r_state <= S_RUN_CMP;
                S_RUN_CMP: begin
                    if (alu_later) begin
                        if (r_have_pend) begin
                            r_o_handle <= 5'(r_pend);
                            r_o_ev     <= 1'b1;
                            r_o_last   <= 1'b1;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_st[r_ord_q] <= stq_pkg::SLOT_EXPIRED;
                        r_slot        <= r_ord_q;
                        if (r_have_pend) begin
                            r_o_handle <= 5'(r_pend);
                            r_o_ev     <= 1'b1;
                            r_o_last   <= 1'b0;
                            r_state    <= S_RESP;
                        end else begin
                            r_state <= S_RUN_POP;
                        end
                    end
                end
                S_RUN_POP: begin
                    r_pend      <= r_slot;
                    r_have_pend <= 1'b1;
                    r_cnt       <= r_cnt + stq_pkg::POP_CNT_W'(1);
                    r_idx       <= '0;
                    r_state     <= S_REM_RD;
                end
                S_REARM_RD: r_state <= S_REARM_ADD;
                S_REARM_ADD: begin
                    r_due   <= alu_sum;
                    r_slot  <= hslot;
                    r_idx   <= '0;
                    r_state <= S_ENQ_RDO;
                end
                S_NEXT_RDD: r_state <= S_NEXT_SUB;
                S_NEXT_SUB: begin
                    r_o_nx  <= alu_later ? alu_sum : 32'd1;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_o_valid) begin
                        r_o_valid <= 1'b1;
                    end else if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        r_state   <= r_o_last ? S_IDLE : S_RUN_POP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = r_state != S_IDLE;
    assign o_valid         = r_o_valid;
    assign o_result_handle = r_o_handle;
    assign o_expired_valid = r_o_ev;
    assign o_next_in_ms    = r_o_nx;
    assign o_status        = r_o_status;
    assign o_last_result   = r_o_last;

endmodule
